FILE: hw/rtl/edf_pkg.sv
// Shared types and codes of the earliest-deadline-first task scheduler.
package edf_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [1:0] KIND_MISS     = 2'd0;
	localparam logic [1:0] KIND_EXEC     = 2'd1;
	localparam logic [1:0] KIND_COMPLETE = 2'd2;
	localparam logic [1:0] KIND_IDLE     = 2'd3;

	typedef struct packed {
		logic        command;
		logic [2:0]  task_slot;
		logic [7:0]  task_label;
		logic [15:0] exec_time;
		logic [15:0] period_len;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [7:0]  event_label;
		logic [2:0]  event_slot;
		logic [31:0] event_time;
		logic [31:0] miss_total;
		logic        last_of_tick;
	} result_item_t;

endpackage

FILE: hw/rtl/edf_task_scheduler.sv
// Earliest-deadline-first task scheduler: slot table, scan sequencer and result register.
//
// The cmd channel takes load and tick commands; the result channel returns events.
// Both use valid and stall; a transfer happens on a rising edge with valid high and
// stall low. cmd_stall is high from the transfer of a command until its last event
// has been placed in the result register.
// A load writes one slot and returns one acknowledge event, which it places in the
// result register as soon as that register can take it.
// A tick walks the slot table once, one slot per cycle unless a slot's miss event must
// wait for the result register, with separate deadline compares that flag misses and
// track the earliest unfinished task, then issues the execute, complete or idle event.
// Each miss event is issued during the walk, in slot order.
// The result register frees the sequencer from the receiver: while result_stall is
// high and an event waits, the walk pauses at the slot that wants to issue the
// next event and resumes, with nothing lost, once the waiting event transfers.
// Reset clears the tick counter, the miss total and all loaded flags; no slot is
// scheduled until a load fills it.
module edf_task_scheduler #(
	parameter int MAX_TASKS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  edf_pkg::cmd_item_t   cmd,
	output logic                 result_valid,
	input  logic                 result_stall,
	output edf_pkg::result_item_t result
);
	import edf_pkg::*;

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_RUN  = 2'd3;

	logic [1:0]           state_q;
	cmd_item_t            cmd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [31:0]          tick_q;
	logic [31:0]          miss_q;
	logic [MAX_TASKS-1:0] loaded_q;

	logic [7:0]  label_q    [MAX_TASKS];
	logic [15:0] exec_q     [MAX_TASKS];
	logic [15:0] period_q   [MAX_TASKS];
	logic [31:0] deadline_q [MAX_TASKS];
	logic [15:0] done_q     [MAX_TASKS];
	logic [15:0] phase_q    [MAX_TASKS];

	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [31:0]      best_dl_q;
	logic [15:0]      best_done_q;
	logic [15:0]      best_exec_q;
	logic [15:0]      best_period_q;
	logic [7:0]       best_label_q;

	logic         result_valid_q;
	result_item_t result_q;

	logic             can_emit;
	logic             cmd_take;
	logic [IDX_W-1:0] load_idx;
	logic             load_ok;
	logic             wr_load;
	logic             slot_ld;
	logic             boundary;
	logic             finished;
	logic             tick_nonzero;
	logic             miss;
	logic             clear_done;
	logic [15:0]      done_after;
	logic             cand;
	logic             better;
	logic             scan_go;
	logic             scan_last;
	logic [16:0]      phase_inc;
	logic [15:0]      phase_next;
	logic [31:0]      miss_next;
	logic             run_go;
	logic [15:0]      done_inc;
	logic             completes;
	logic             emit;
	result_item_t     emit_data;

	assign cmd_stall    = (state_q != S_IDLE);
	assign cmd_take     = cmd_valid && !cmd_stall;
	assign can_emit     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign load_idx = IDX_W'(cmd_q.task_slot);
	assign load_ok  = (32'(cmd_q.task_slot) < 32'(MAX_TASKS));
	assign wr_load  = (state_q == S_LOAD) && can_emit && load_ok;

	// One slot per cycle unless a miss waits: period check, then the running earliest-deadline compare.
	assign slot_ld      = loaded_q[idx_q];
	assign boundary     = (phase_q[idx_q] == 16'd0);
	assign finished     = (done_q[idx_q] == exec_q[idx_q]);
	assign tick_nonzero = (tick_q != 32'd0);
	assign miss         = slot_ld && tick_nonzero &&
	                      (boundary ? !finished : (tick_q > deadline_q[idx_q]));
	assign clear_done   = slot_ld && tick_nonzero && boundary && finished;
	assign done_after   = clear_done ? 16'd0 : done_q[idx_q];
	assign cand         = slot_ld && (done_after != exec_q[idx_q]);
	assign better       = cand && (!found_q || (deadline_q[idx_q] < best_dl_q));
	assign scan_go      = (state_q == S_SCAN) && (!miss || can_emit);
	assign scan_last    = (idx_q == IDX_W'(MAX_TASKS - 1));
	assign phase_inc    = {1'b0, phase_q[idx_q]} + 17'd1;
	assign phase_next   = (phase_inc >= {1'b0, period_q[idx_q]}) ? 16'd0 : phase_inc[15:0];
	assign miss_next    = (miss_q == 32'hFFFF_FFFF) ? miss_q : miss_q + 32'd1;

	assign run_go    = (state_q == S_RUN) && can_emit;
	assign done_inc  = best_done_q + 16'd1;
	assign completes = (done_inc == best_exec_q);

	always_comb begin
		emit      = 1'b0;
		emit_data = '0;
		emit_data.event_time = tick_q;
		emit_data.miss_total = miss_q;
		unique case (state_q)
			S_LOAD: begin
				emit = can_emit;
				emit_data.event_kind   = KIND_IDLE;
				emit_data.event_label  = cmd_q.task_label;
				emit_data.event_slot   = cmd_q.task_slot;
				emit_data.last_of_tick = 1'b1;
			end
			S_SCAN: begin
				emit = scan_go && miss;
				emit_data.event_kind  = KIND_MISS;
				emit_data.event_label = label_q[idx_q];
				emit_data.event_slot  = 3'(idx_q);
				emit_data.miss_total  = miss_next;
			end
			S_RUN: begin
				emit = can_emit;
				emit_data.last_of_tick = 1'b1;
				if (found_q) begin
					emit_data.event_kind  = completes ? KIND_COMPLETE : KIND_EXEC;
					emit_data.event_label = best_label_q;
					emit_data.event_slot  = 3'(best_idx_q);
				end else begin
					emit_data.event_kind = KIND_IDLE;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			idx_q          <= '0;
			tick_q         <= '0;
			miss_q         <= '0;
			loaded_q       <= '0;
			found_q        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						state_q <= (cmd.command == CMD_TICK) ? S_SCAN : S_LOAD;
					end
				end
				S_LOAD: begin
					if (can_emit) begin
						if (load_ok) begin
							loaded_q[load_idx] <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (scan_go) begin
						if (miss) begin
							miss_q <= miss_next;
						end
						if (better) begin
							found_q <= 1'b1;
						end
						idx_q <= idx_q + IDX_W'(1);
						if (scan_last) begin
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (can_emit) begin
						tick_q  <= tick_q + 32'd1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command register, slot table, the scan's running best and result register; these hold payload only.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_take) begin
			cmd_q <= cmd;
		end
		if (wr_load) begin
			label_q[load_idx]    <= cmd_q.task_label;
			exec_q[load_idx]     <= cmd_q.exec_time;
			period_q[load_idx]   <= cmd_q.period_len;
			deadline_q[load_idx] <= {16'd0, cmd_q.period_len};
			done_q[load_idx]     <= 16'd0;
			phase_q[load_idx]    <= 16'd0;
		end
		if (scan_go) begin
			if (slot_ld) begin
				phase_q[idx_q] <= phase_next;
			end
			if (clear_done) begin
				done_q[idx_q] <= 16'd0;
			end
			if (better) begin
				best_idx_q    <= idx_q;
				best_dl_q     <= deadline_q[idx_q];
				best_done_q   <= done_after;
				best_exec_q   <= exec_q[idx_q];
				best_period_q <= period_q[idx_q];
				best_label_q  <= label_q[idx_q];
			end
		end
		if (run_go && found_q) begin
			done_q[best_idx_q] <= done_inc;
			if (completes) begin
				deadline_q[best_idx_q] <= best_dl_q + {16'd0, best_period_q};
			end
		end
		if (emit) begin
			result_q <= emit_data;
		end
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> (state_q != S_IDLE))
		else $error("accepted command did not start the sequencer");

	a_run_ends_tick: assert property (@(posedge clk) disable iff (!arst_n)
		run_go |=> (result_valid_q && result_q.last_of_tick && state_q == S_IDLE))
		else $error("tick did not end with a final event");

	a_miss_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (miss_q >= $past(miss_q)))
		else $error("miss total decreased");

	a_scan_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (32'(idx_q) < 32'(MAX_TASKS)))
		else $error("scan index beyond the slot table");

	a_stalled_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && result_stall) |=> (result_valid_q && $stable(result_q)))
		else $error("stalled result changed");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the EDF task scheduler: directed table, then randomized traffic.
module tb_top;
	import edf_pkg::*;

	typedef struct packed {
		cmd_item_t    item;
		logic         typed;
		result_item_t want;
	} dir_row_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cmd_valid = 1'b0;
	logic         cmd_stall;
	cmd_item_t    cmd = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result;

	// Scheduler state as the testbench expects it.
	logic [31:0] sched_tick;
	logic [31:0] sched_misses;
	logic        slot_used [8];
	logic [7:0]  slot_name [8];
	logic [15:0] slot_need [8];
	logic [15:0] slot_per [8];
	logic [31:0] slot_due [8];
	logic [15:0] slot_ran [8];
	logic [15:0] slot_ph [8];

	result_item_t caused_events[$];
	result_item_t expected_events[$];
	dir_row_t     dir_rows[$];

	int mismatches = 0;
	int cmd_idle_pct = 0;
	int res_stall_pct = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	edf_task_scheduler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.cmd          (cmd),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#6000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic result_item_t make_event(logic [1:0] kind, logic [7:0] label,
			logic [2:0] slot, logic [31:0] at, logic last);
		result_item_t ev;
		ev.event_kind   = kind;
		ev.event_label  = label;
		ev.event_slot   = slot;
		ev.event_time   = at;
		ev.miss_total   = sched_misses;
		ev.last_of_tick = last;
		return ev;
	endfunction

	function automatic void add_caused(result_item_t ev);
		caused_events.insert(caused_events.size(), ev);
	endfunction

	function automatic void add_expected(result_item_t ev);
		expected_events.insert(expected_events.size(), ev);
	endfunction

	// Applies one command to the expected state and collects the events it causes.
	task automatic edf_advance(input cmd_item_t it);
		logic [31:0] now;
		logic [31:0] nxt;
		logic        boundary;
		logic [1:0]  kind;
		int          pick;
		now = sched_tick;
		pick = -1;
		caused_events.delete();
		if (it.command == CMD_LOAD) begin
			slot_used[it.task_slot] = 1'b1;
			slot_name[it.task_slot] = it.task_label;
			slot_need[it.task_slot] = it.exec_time;
			slot_per[it.task_slot]  = it.period_len;
			slot_due[it.task_slot]  = {16'h0, it.period_len};
			slot_ran[it.task_slot]  = '0;
			slot_ph[it.task_slot]   = '0;
			add_caused(make_event(KIND_IDLE, it.task_label, it.task_slot, now, 1'b1));
		end else begin
			for (int s = 0; s < 8; s++) begin
				if (!slot_used[s])
					continue;
				boundary = (slot_ph[s] == 16'h0);
				nxt = {16'h0, slot_ph[s]} + 32'd1;
				slot_ph[s] = (nxt >= {16'h0, slot_per[s]}) ? 16'h0 : nxt[15:0];
				// The very first tick only moves the phase counters.
				if (now == 32'd0)
					continue;
				if (!boundary) begin
					if (now > slot_due[s]) begin
						if (sched_misses != '1)
							sched_misses++;
						add_caused(make_event(KIND_MISS, slot_name[s], 3'(s), now, 1'b0));
					end
				end else if (slot_ran[s] == slot_need[s]) begin
					slot_ran[s] = '0;
				end else begin
					if (sched_misses != '1)
						sched_misses++;
					add_caused(make_event(KIND_MISS, slot_name[s], 3'(s), now, 1'b0));
				end
			end
			for (int s = 0; s < 8; s++) begin
				if (!slot_used[s] || slot_ran[s] == slot_need[s])
					continue;
				if (pick < 0 || slot_due[s] < slot_due[pick])
					pick = s;
			end
			if (pick < 0) begin
				add_caused(make_event(KIND_IDLE, 8'h00, 3'd0, now, 1'b1));
			end else begin
				kind = KIND_EXEC;
				slot_ran[pick] = slot_ran[pick] + 16'd1;
				if (slot_ran[pick] == slot_need[pick]) begin
					kind = KIND_COMPLETE;
					slot_due[pick] = slot_due[pick] + {16'h0, slot_per[pick]};
				end
				add_caused(make_event(kind, slot_name[pick], 3'(pick), now, 1'b1));
			end
			sched_tick = now + 32'd1;
		end
	endtask

	function automatic cmd_item_t load_cmd(logic [2:0] slot, logic [7:0] label,
			logic [15:0] need, logic [15:0] per);
		cmd_item_t it;
		it.command    = CMD_LOAD;
		it.task_slot  = slot;
		it.task_label = label;
		it.exec_time  = need;
		it.period_len = per;
		return it;
	endfunction

	// Tick commands carry random don't-care fields.
	function automatic cmd_item_t tick_cmd();
		cmd_item_t it;
		it.command    = CMD_TICK;
		it.task_slot  = 3'($urandom_range(7));
		it.task_label = 8'($urandom_range(255));
		it.exec_time  = 16'($urandom_range(65535));
		it.period_len = 16'($urandom_range(65535));
		return it;
	endfunction

	function automatic void add_row(cmd_item_t item, logic typed, result_item_t want);
		dir_row_t row;
		row.item  = item;
		row.typed = typed;
		row.want  = want;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	// Presents one command, waits for its transfer and records what it should cause.
	task automatic offer(input cmd_item_t it, input logic typed, input result_item_t want);
		while ($urandom_range(99) < cmd_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= it;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		edf_advance(it);
		if (typed)
			add_expected(want);
		else
			foreach (caused_events[i])
				add_expected(caused_events[i]);
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic random_items(input int count);
		cmd_item_t   it;
		logic [15:0] per;
		for (int i = 0; i < count; i++) begin
			it = tick_cmd();
			if ($urandom_range(99) < 22) begin
				if ($urandom_range(9) == 0) begin
					per = 16'($urandom_range(65535, 1));
					it = load_cmd(3'($urandom_range(7)), 8'($urandom_range(255)),
						16'($urandom_range(65535)), per);
				end else begin
					// Short periods keep boundaries, misses and completions frequent.
					per = 16'($urandom_range(12, 1));
					it = load_cmd(3'($urandom_range(7)), 8'($urandom_range(255)),
						16'($urandom_range(32'(per) + 32'd1)), per);
				end
			end
			offer(it, 1'b0, '0);
		end
	endtask

	task automatic check_event(input result_item_t got);
		result_item_t want;
		if (expected_events.size() == 0) begin
			$error("result transfer with no event expected: kind %0d slot %0d time %0d",
				got.event_kind, got.event_slot, got.event_time);
			mismatches++;
		end else begin
			want = expected_events.pop_front();
			if (got.event_kind !== want.event_kind) begin
				$error("event_kind: expected %0d, actual %0d", want.event_kind, got.event_kind);
				mismatches++;
			end
			if (got.event_label !== want.event_label) begin
				$error("event_label: expected %0d, actual %0d", want.event_label,
					got.event_label);
				mismatches++;
			end
			if (got.event_slot !== want.event_slot) begin
				$error("event_slot: expected %0d, actual %0d", want.event_slot, got.event_slot);
				mismatches++;
			end
			if (got.event_time !== want.event_time) begin
				$error("event_time: expected %0d, actual %0d", want.event_time, got.event_time);
				mismatches++;
			end
			if (got.miss_total !== want.miss_total) begin
				$error("miss_total: expected %0d, actual %0d", want.miss_total, got.miss_total);
				mismatches++;
			end
			if (got.last_of_tick !== want.last_of_tick) begin
				$error("last_of_tick: expected %0d, actual %0d", want.last_of_tick,
					got.last_of_tick);
				mismatches++;
			end
		end
	endtask

	// Result side: checks each transfer and decides the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			check_event(result);
		if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= 250;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < res_stall_pct);
		end
	end

	initial begin
		sched_tick = '0;
		sched_misses = '0;
		foreach (slot_used[s]) begin
			slot_used[s] = 1'b0;
			slot_name[s] = '0;
			slot_need[s] = '0;
			slot_per[s]  = '0;
			slot_due[s]  = '0;
			slot_ran[s]  = '0;
			slot_ph[s]   = '0;
		end

		add_row(tick_cmd(), 1'b1, '{KIND_IDLE, 8'h00, 3'd0, 32'd0, 32'd0, 1'b1});
		// Zero execution time with the longest period; then a task that can never finish.
		add_row(load_cmd(3'd0, 8'hFF, 16'h0000, 16'hFFFF), 1'b1,
			'{KIND_IDLE, 8'hFF, 3'd0, 32'd1, 32'd0, 1'b1});
		add_row(load_cmd(3'd7, 8'h00, 16'hFFFF, 16'h0001), 1'b1,
			'{KIND_IDLE, 8'h00, 3'd7, 32'd1, 32'd0, 1'b1});
		add_row(tick_cmd(), 1'b0, '0);
		add_row(load_cmd(3'd3, 8'hA5, 16'd2, 16'd3), 1'b0, '0);
		// A zero period makes every tick a boundary.
		add_row(load_cmd(3'd5, 8'h5A, 16'd1, 16'd0), 1'b0, '0);
		add_row(load_cmd(3'd1, 8'h11, 16'd3, 16'd4), 1'b0, '0);
		add_row(load_cmd(3'd2, 8'h22, 16'd1, 16'd2), 1'b0, '0);
		add_row(load_cmd(3'd4, 8'h44, 16'd5, 16'd6), 1'b0, '0);
		add_row(load_cmd(3'd6, 8'h66, 16'd2, 16'd2), 1'b0, '0);
		repeat (12) add_row(tick_cmd(), 1'b0, '0);
		add_row(load_cmd(3'd7, 8'h77, 16'd1, 16'd5), 1'b0, '0);
		repeat (2) add_row(tick_cmd(), 1'b0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		drain_results();

		random_items(110);
		drain_results();

		cmd_idle_pct = 69;
		random_items(110);
		drain_results();

		cmd_idle_pct = 0;
		res_stall_pct <= 69;
		random_items(100);
		drain_results();

		cmd_idle_pct = 10;
		res_stall_pct <= 10;
		random_items(90);
		drain_results();

		// Long receiver hold-off while commands keep coming, so the block backs up.
		cmd_idle_pct = 0;
		res_stall_pct <= 0;
		hold_seq <= hold_seq + 1;
		random_items(30);
		drain_results();

		if (mismatches == 0 && expected_events.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
